>>> hdl/dwcs_pkg.sv
package dwcs_pkg;

  // Default number of delay taps in one sweep.
  localparam int unsigned DELAY_STEPS_DEF = 32;

  // Fixed widths of the beat fields.
  localparam int unsigned BDLY_W = 5;
  localparam int unsigned LEN_W  = 6;

  // min_run after reset.
  localparam logic [LEN_W-1:0] MIN_RUN_RST = LEN_W'(6);

  typedef struct packed {
    logic passed;
    logic last;
  } in_beat_t;

  typedef struct packed {
    logic [BDLY_W-1:0] best_delay;
    logic [LEN_W-1:0]  window_length;
    logic              found;
  } out_beat_t;

  // Registered input beat handed from the input stage to the tracker.
  typedef struct packed {
    logic     vld;
    in_beat_t beat;
  } s1_item_t;

endpackage

>>> hdl/dwcs_in_reg.sv
module dwcs_in_reg
  import dwcs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_beat_t in_data,
  input  logic     take,
  output s1_item_t item
);

  logic     vld_r;
  in_beat_t beat_r;

  // The slot is free when empty or when its beat leaves this cycle.
  assign in_ready = !vld_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      beat_r <= in_data;
    end
  end

  assign item.vld  = vld_r;
  assign item.beat = beat_r;

endmodule

>>> hdl/dwcs_tracker.sv
module dwcs_tracker
  import dwcs_pkg::*;
#(
  parameter int unsigned DELAY_STEPS = DELAY_STEPS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [LEN_W-1:0] min_run,
  input  s1_item_t         item,
  input  logic             res_free,
  output logic             take,
  output logic             res_valid,
  output out_beat_t        res
);

  localparam int unsigned DLY_W = $clog2(DELAY_STEPS);
  localparam int unsigned RL_W  = $clog2(DELAY_STEPS + 1);

  logic [DLY_W-1:0] idx_r, idx_nxt;
  logic [DLY_W-1:0] run_start_r, run_start_nxt;
  logic [RL_W-1:0]  run_len_r, run_len_nxt;
  logic [DLY_W-1:0] best_start_r, best_start_nxt;
  logic [RL_W-1:0]  best_len_r, best_len_nxt;

  logic             is_final;
  logic             do_close;
  logic             keep;
  logic [LEN_W-1:0] need;
  logic [DLY_W-1:0] cand_start;
  logic [RL_W-1:0]  cand_len;
  logic [DLY_W-1:0] sel_start;
  logic [RL_W-1:0]  sel_len;
  logic [RL_W-1:0]  half_len;

  assign is_final = item.beat.last || (idx_r == DLY_W'(DELAY_STEPS - 1));
  // A final beat needs room in the result register; others never stall.
  assign take      = item.vld && (!is_final || res_free);
  assign res_valid = item.vld && is_final && res_free;

  assign need = (min_run == '0) ? LEN_W'(1) : min_run;

  always_comb begin
    // The run as it stands after this beat, if the beat extends it.
    if (item.beat.passed) begin
      cand_start = (run_len_r == '0) ? idx_r : run_start_r;
      cand_len   = run_len_r + RL_W'(1);
    end else begin
      cand_start = run_start_r;
      cand_len   = run_len_r;
    end
    do_close  = !item.beat.passed || is_final;
    keep      = do_close && (LEN_W'(cand_len) >= need) && (cand_len > best_len_r);
    sel_start = keep ? cand_start : best_start_r;
    sel_len   = keep ? cand_len : best_len_r;

    idx_nxt        = idx_r;
    run_start_nxt  = run_start_r;
    run_len_nxt    = run_len_r;
    best_start_nxt = best_start_r;
    best_len_nxt   = best_len_r;
    if (take) begin
      if (is_final) begin
        idx_nxt        = '0;
        run_start_nxt  = '0;
        run_len_nxt    = '0;
        best_start_nxt = '0;
        best_len_nxt   = '0;
      end else begin
        idx_nxt        = idx_r + DLY_W'(1);
        run_start_nxt  = do_close ? '0 : cand_start;
        run_len_nxt    = do_close ? '0 : cand_len;
        best_start_nxt = sel_start;
        best_len_nxt   = sel_len;
      end
    end
  end

  assign half_len = (sel_len - RL_W'(1)) >> 1;

  always_comb begin
    if (sel_len != '0) begin
      res.best_delay    = BDLY_W'(sel_start) + BDLY_W'(half_len);
      res.window_length = LEN_W'(sel_len);
      res.found         = 1'b1;
    end else begin
      res.best_delay    = '0;
      res.window_length = '0;
      res.found         = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r        <= '0;
      run_start_r  <= '0;
      run_len_r    <= '0;
      best_start_r <= '0;
      best_len_r   <= '0;
    end else begin
      idx_r        <= idx_nxt;
      run_start_r  <= run_start_nxt;
      run_len_r    <= run_len_nxt;
      best_start_r <= best_start_nxt;
      best_len_r   <= best_len_nxt;
    end
  end

endmodule

>>> hdl/dwcs_out_reg.sv
module dwcs_out_reg
  import dwcs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      res_valid,
  input  out_beat_t res,
  output logic      res_free,
  output logic      out_valid,
  input  logic      out_ready,
  output out_beat_t out_data
);

  logic      vld_r;
  out_beat_t data_r;

  assign res_free = !vld_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (res_free) begin
      vld_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_free && res_valid) begin
      data_r <= res;
    end
  end

  assign out_valid = vld_r;
  assign out_data  = data_r;

endmodule

>>> hdl/delay_window_center_search.sv
// Finds the center of the longest passing input-delay window of one lane.
// The input channel takes one beat per delay tap, in rising tap order: the
// pass flag of the pattern test and a last flag on the final tap. The tap
// with index DELAY_STEPS-1 also ends the sweep. On the final beat the block
// emits one result beat: midpoint delay, window length and a found flag;
// runs shorter than min_run are ignored and ties keep the earliest run.
// Non-final beats produce no output. The cfg_ port writes min_run; the user
// must use it only while no sweep is in flight; the block does not enforce
// it. Throughput is one beat per cycle while the result register can take a
// final beat. A beat is captured in an input register and processed by the
// run tracker, and the result of a final beat is captured in the result
// register that drives out_valid. The result register lets the next sweep
// start while an unread result waits; when the receiver stalls, only a
// further final beat is held back, and that back-pressure reaches in_ready.
// Synchronous reset empties both registers, clears the sweep state and sets
// min_run to 6.
module delay_window_center_search
  import dwcs_pkg::*;
#(
  parameter int unsigned DELAY_STEPS = DELAY_STEPS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_beat_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_beat_t        out_data,
  input  logic             cfg_we,
  input  logic [LEN_W-1:0] cfg_wdata
);

  logic [LEN_W-1:0] min_run_r;
  s1_item_t         item;
  logic             take;
  logic             res_valid;
  logic             res_free;
  out_beat_t        res;

  // The single configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_run_r <= MIN_RUN_RST;
    end else if (cfg_we) begin
      min_run_r <= cfg_wdata;
    end
  end

  // Input register: holds the beat that the tracker works on.
  dwcs_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .take     (take),
    .item     (item)
  );

  // Run tracker: tap index, open run and best run so far; closes the sweep.
  dwcs_tracker #(
    .DELAY_STEPS (DELAY_STEPS)
  ) u_tracker (
    .clk       (clk),
    .rst_n     (rst_n),
    .min_run   (min_run_r),
    .item      (item),
    .res_free  (res_free),
    .take      (take),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register toward the receiver.
  dwcs_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .res_free  (res_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

>>> bench/delay_window_center_search_test.sv
module delay_window_center_search_test;
  import dwcs_pkg::*;

  // The block runs with its default sweep depth, so the last tap index is 31.
  localparam int unsigned TAPS = DELAY_STEPS_DEF;

  // Minimum number of random beats in each min_run phase.
  localparam int PHASE_TAPS = 135;

  // Length of the receiver hold-off, and the accepted beat count that starts it.
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AFTER_TAPS = 200;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_ready;
  in_beat_t         in_data;
  logic             out_valid;
  logic             out_ready;
  out_beat_t        out_data;
  logic             cfg_we;
  logic [LEN_W-1:0] cfg_wdata;

  delay_window_center_search dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Shadow copy of the window tracker. The sweep state is advanced once per
  // accepted input beat, and min_run follows every register write.
  logic [BDLY_W-1:0] tap_idx;
  logic [BDLY_W-1:0] run_first;
  logic [LEN_W-1:0]  run_len;
  logic [BDLY_W-1:0] win_first;
  logic [LEN_W-1:0]  win_len;
  logic [LEN_W-1:0]  min_run_q;

  // Windows that the block still owes us, oldest first.
  out_beat_t pending_windows[$];

  int  mismatches = 0;
  int  taps_accepted = 0;
  // While calm is set neither side inserts idle cycles.
  bit  calm = 1'b0;
  bit  hold_done = 1'b0;

  // One row of the directed sweep table. A row repeats its beat reps times.
  // When typed is set, the last repetition closes a sweep whose result is
  // obvious, and that value is expected instead of the tracker's own.
  typedef struct {
    in_beat_t  beat;
    int        reps;
    bit        typed;
    out_beat_t want;
  } tap_row_t;

  localparam int PLAN_ROWS = 11;

  tap_row_t plan [PLAN_ROWS] = '{
    // A one-tap sweep that fails: nothing is found.
    '{'{1'b0, 1'b1}, 1, 1'b1, '{5'd0, 6'd0, 1'b0}},
    // A one-tap sweep that passes, far below the reset min_run of 6.
    '{'{1'b1, 1'b1}, 1, 1'b1, '{5'd0, 6'd0, 1'b0}},
    // Every tap passes and last never comes: the sweep is cut at the last
    // tap, and the open run of all 32 taps is taken there.
    '{'{1'b1, 1'b0}, 32, 1'b1, '{5'd15, 6'd32, 1'b1}},
    // Two runs of exactly min_run, the second ending on the final tap: the
    // tie keeps the earlier run, centered at tap 2.
    '{'{1'b1, 1'b0}, 6, 1'b0, '{5'd0, 6'd0, 1'b0}},
    '{'{1'b0, 1'b0}, 1, 1'b0, '{5'd0, 6'd0, 1'b0}},
    '{'{1'b1, 1'b0}, 5, 1'b0, '{5'd0, 6'd0, 1'b0}},
    '{'{1'b1, 1'b1}, 1, 1'b1, '{5'd2, 6'd6, 1'b1}},
    // A run one short of min_run is dropped; the run of six that follows
    // and closes on the final tap is centered at tap 8.
    '{'{1'b1, 1'b0}, 5, 1'b0, '{5'd0, 6'd0, 1'b0}},
    '{'{1'b0, 1'b0}, 1, 1'b0, '{5'd0, 6'd0, 1'b0}},
    '{'{1'b1, 1'b0}, 5, 1'b0, '{5'd0, 6'd0, 1'b0}},
    '{'{1'b1, 1'b1}, 1, 1'b1, '{5'd8, 6'd6, 1'b1}}
  };

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  function automatic void clear_sweep_state();
    tap_idx   = '0;
    run_first = '0;
    run_len   = '0;
    win_first = '0;
    win_len   = '0;
  endfunction

  // Judges the open run against min_run; a zero min_run behaves as one.
  // Only a strictly longer run replaces the best one, so ties keep the
  // earliest window.
  function automatic void close_open_run();
    logic [LEN_W-1:0] need;
    need = (min_run_q == '0) ? LEN_W'(1) : min_run_q;
    if (run_len >= need && run_len > win_len) begin
      win_first = run_first;
      win_len   = run_len;
    end
    run_len   = '0;
    run_first = '0;
  endfunction

  // Advances the tracker by one tap. Returns 1 when the tap ends the sweep,
  // with the window result in res.
  function automatic bit track_tap(input in_beat_t b, output out_beat_t res);
    logic final_tap;
    final_tap = b.last || (tap_idx == BDLY_W'(TAPS - 1));
    res = '0;
    if (b.passed) begin
      if (run_len == '0) run_first = tap_idx;
      run_len = run_len + LEN_W'(1);
    end else begin
      close_open_run();
    end
    if (!final_tap) begin
      tap_idx = tap_idx + BDLY_W'(1);
      return 1'b0;
    end
    close_open_run();
    if (win_len != '0) begin
      res.best_delay    = win_first + BDLY_W'((win_len - LEN_W'(1)) >> 1);
      res.window_length = win_len;
      res.found         = 1'b1;
    end
    clear_sweep_state();
    return 1'b1;
  endfunction

  // Offers one beat, holding it until the block takes it, then updates the
  // tracker. Unless calm is set, about one beat in ten is preceded by a short idle gap.
  task automatic send_tap(input in_beat_t b, input bit typed, input out_beat_t want);
    out_beat_t res;
    if (!calm && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
    taps_accepted++;
    if (track_tap(b, res)) pending_windows = {pending_windows, (typed ? want : res)};
  endtask

  // Stops offering beats and waits until every owed window has come out.
  // The extra cycles cover the input register and the tracker stage, so
  // the block is truly idle before the next register write.
  task automatic drain_windows();
    in_valid <= 1'b0;
    while (pending_windows.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_min_run(input logic [LEN_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    min_run_q = value;
  endtask

  // Sends whole sweeps of random content until at least n beats went out.
  // Most sweeps end on a random tap with last; some never raise last and
  // run into the last tap. The pass density varies per sweep so that runs
  // of every length near min_run come up.
  task automatic random_sweeps(input int n);
    int        sent;
    int        sweep_len;
    int        density;
    bit        no_last;
    in_beat_t  b;
    out_beat_t none;
    sent = 0;
    none = '0;
    while (sent < n) begin
      no_last = ($urandom_range(99) < 15);
      sweep_len = no_last ? TAPS : $urandom_range(1, TAPS);
      case ($urandom_range(3))
        0: density = 15;
        1: density = 50;
        2: density = 85;
        default: density = 100;
      endcase
      for (int i = 0; i < sweep_len; i++) begin
        b.passed = ($urandom_range(99) < density);
        b.last   = !no_last && (i == sweep_len - 1);
        send_tap(b, 1'b0, none);
        sent++;
      end
    end
  endtask

  // Result checker: every beat taken from the output is matched, field by
  // field, against the oldest owed window.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_windows.size() == 0) begin
        report_mismatch($sformatf("result with nothing owed: delay %0d length %0d found %0b",
                                  out_data.best_delay, out_data.window_length,
                                  out_data.found));
      end else begin
        if (out_data.best_delay !== pending_windows[0].best_delay)
          report_mismatch($sformatf("best_delay %0d, expected %0d", out_data.best_delay,
                                    pending_windows[0].best_delay));
        if (out_data.window_length !== pending_windows[0].window_length)
          report_mismatch($sformatf("window_length %0d, expected %0d",
                                    out_data.window_length,
                                    pending_windows[0].window_length));
        if (out_data.found !== pending_windows[0].found)
          report_mismatch($sformatf("found %0b, expected %0b", out_data.found,
                                    pending_windows[0].found));
        void'(pending_windows.pop_front());
      end
    end
  end

  // Receiver. It stalls on about one cycle in ten, never while calm is set.
  // Once, after enough beats went in, it holds off for a long stretch so
  // that an unread result blocks the next final beat and in_ready drops.
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!hold_done && taps_accepted >= HOLD_AFTER_TAPS) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 10);
        @(posedge clk);
      end
    end
  end

  // Run limit, far above the slowest legal run.
  initial begin
    #400000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic [LEN_W-1:0] phase_min_run [8];
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    min_run_q = MIN_RUN_RST;
    clear_sweep_state();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed sweeps with the reset min_run.
    for (int r = 0; r < PLAN_ROWS; r++) begin
      for (int k = 0; k < plan[r].reps; k++) begin
        send_tap(plan[r].beat, plan[r].typed && (k == plan[r].reps - 1), plan[r].want);
      end
    end
    drain_windows();

    // Random phases. The first keeps min_run from reset; the others cover
    // one, the full sweep, zero (treated as one), all ones and just above
    // the sweep depth (nothing can qualify), and two random mid values.
    phase_min_run = '{6'd6, 6'd1, 6'd32, 6'd0, 6'd63, 6'd33,
                      LEN_W'($urandom_range(2, 31)), LEN_W'($urandom_range(2, 31))};
    for (int ph = 0; ph < 8; ph++) begin
      if (ph != 0) write_min_run(phase_min_run[ph]);
      // The zero min_run phase runs back to back on both sides.
      calm = (ph == 3);
      random_sweeps(PHASE_TAPS);
      drain_windows();
      calm = 1'b0;
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
